>>> sv/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int LCS_MAX_ROWS = 64;

    localparam int SYM_W   = 8;
    localparam int SCORE_W = 32;
    localparam int ROW_W   = 6;
    localparam int HEIGHT_W = 7;
    localparam int WIDTH_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

    localparam logic KIND_BOTTOM = 1'b0;
    localparam logic KIND_BORDER = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CORNER = 2'd1,
        CMD_COLUMN = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [ROW_W-1:0]   row_index;
        logic [SYM_W-1:0]   symbol;
        logic [SCORE_W-1:0] border_value;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               kind;
        logic               last;
    } t_out_item;

    // column wavefront token handed from one row cell to the next
    typedef struct packed {
        logic               valid;
        logic [SYM_W-1:0]   sym;
        logic [SCORE_W-1:0] up;
        logic [SCORE_W-1:0] diag;
        logic               last;
    } t_tok;

endpackage

>>> sv/lcs_cell.sv
`timescale 1ns / 1ps

module lcs_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_active,
    input  logic                        i_load,
    input  logic [lcs_pkg::SYM_W-1:0]   i_load_sym,
    input  logic [lcs_pkg::SCORE_W-1:0] i_load_score,
    input  lcs_pkg::t_tok               i_tok,
    output lcs_pkg::t_tok               o_tok,
    output logic [lcs_pkg::SCORE_W-1:0] o_score
);
    import lcs_pkg::*;

    logic [SYM_W-1:0]   r_sym;
    logic [SCORE_W-1:0] r_score;
    logic               r_valid;
    logic [SYM_W-1:0]   r_sym_b;
    logic [SCORE_W-1:0] r_up;
    logic [SCORE_W-1:0] r_diag;
    logic               r_last;
    logic               w_take;
    logic [SCORE_W-1:0] w_cell;

    assign w_take = i_adv && i_tok.valid && i_active;

    always_comb begin
        if (r_sym == i_tok.sym) begin
            // diagonal plus one, held at full scale
            w_cell = (i_tok.diag == {SCORE_W{1'b1}}) ? i_tok.diag : i_tok.diag + 1'b1;
        end else begin
            w_cell = (i_tok.up > r_score) ? i_tok.up : r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_tok.valid && i_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_score <= w_cell;
            r_sym_b <= i_tok.sym;
            r_up    <= w_cell;
            r_diag  <= r_score;
            r_last  <= i_tok.last;
        end else if (i_load) begin
            r_score <= i_load_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sym <= i_load_sym;
        end
    end

    assign o_tok = '{valid: r_valid, sym: r_sym_b, up: r_up, diag: r_diag, last: r_last};
    assign o_score = r_score;

endmodule

>>> sv/lcs_tile_score_engine.sv
`timescale 1ns / 1ps
// LCS tile score engine: one tile of the longest-common-subsequence table.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) carries items:
//   load row     - symbol of A and left border score for one row cell
//   set corner   - diagonal value above row 0; restarts the column count
//   column       - symbol of B and top border; yields the bottom score
//   read border  - returns the stored score of one row (the right border)
// Output channel (o_out_valid / i_out_stall, payload o_out_data) returns
// one item per column or read. Configuration: i_cfg_we writes the row count
// (index 0) or the column count of the tile (index 1) from i_cfg_data.
// A column item walks down a chain of row cells, one cell per cycle unless the
// output stalls; its score leaves the bottom cell (row h-1, h = tile height)
// through the output register. Columns enter back to back, one per cycle; load,
// corner and read items wait until the chain holds no column, reads then answer
// through the output register. A stalled output holds the chain; no item is taken.
// Synchronous reset clears the chain's valid bits, the output valid bit, the
// corner value and the column count, and sets height and width to 64.
// Row symbols and scores are undefined until loaded.

module lcs_tile_score_engine #(
    parameter int MAX_ROWS = lcs_pkg::LCS_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lcs_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lcs_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcs_pkg::*;

    localparam int H_W = $clog2(MAX_ROWS + 1);

    logic [HEIGHT_W-1:0] r_rows;
    logic [WIDTH_W-1:0]  r_cols;
    logic [SCORE_W-1:0]  r_prev_top;
    logic [WIDTH_W-1:0]  r_col_count;
    logic [WIDTH_W-1:0]  n_col_count;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [H_W-1:0]      w_h_eff;
    logic [MAX_ROWS-1:0] w_active;
    logic [MAX_ROWS-1:0] w_bottom;
    logic [MAX_ROWS-1:0] w_load_en;
    logic [MAX_ROWS-1:0] w_tok_valid;
    t_tok                w_tok [MAX_ROWS];
    logic [SCORE_W-1:0]  w_score [MAX_ROWS];
    t_tok                w_head;
    t_tok                w_tap;
    logic [SCORE_W-1:0]  w_rd_score;
    logic                w_adv;
    logic                w_busy;
    logic                w_in_acc;
    logic                w_col_acc;
    logic                w_load_acc;
    logic                w_rd_acc;
    logic                w_last;

    // Advance the chain whenever the output register is free or being taken.
    assign w_adv = !r_out_valid || !i_out_stall;
    assign w_busy = |w_tok_valid;

    // Hold non-column items until every column in flight has left the chain.
    assign o_in_stall = !w_adv || ((i_in_data.cmd != CMD_COLUMN) && w_busy);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_col_acc  = w_in_acc && (i_in_data.cmd == CMD_COLUMN);
    assign w_load_acc = w_in_acc && (i_in_data.cmd == CMD_LOAD);
    assign w_rd_acc   = w_in_acc && (i_in_data.cmd == CMD_READ);

    // Clamp the configured height to the chain length; a height of zero counts as one.
    always_comb begin
        if (r_rows == '0) begin
            w_h_eff = H_W'(1);
        end else if (32'(r_rows) > 32'(MAX_ROWS)) begin
            w_h_eff = H_W'(MAX_ROWS);
        end else begin
            w_h_eff = H_W'(r_rows);
        end
    end

    // Column count saturates; last marks the column that reaches the width.
    assign n_col_count = (r_col_count != {WIDTH_W{1'b1}}) ? r_col_count + 1'b1
                                                           : r_col_count;
    assign w_last = (r_cols != '0) && (n_col_count == r_cols);

    assign w_head = '{valid: w_col_acc, sym: i_in_data.symbol,
                      up: i_in_data.border_value, diag: r_prev_top, last: w_last};

    always_comb begin
        for (int i = 0; i < MAX_ROWS; i++) begin
            w_active[i]    = H_W'(i) < w_h_eff;
            w_bottom[i]    = H_W'(i + 1) == w_h_eff;
            w_load_en[i]   = w_load_acc && (32'(i_in_data.row_index) == 32'(i));
            w_tok_valid[i] = w_tok[i].valid;
        end
    end

    // Row cells: each keeps one A symbol and one column score and passes the
    // column wavefront to the row below.
    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
        t_tok w_cell_in;
        if (g == 0) begin : g_first
            assign w_cell_in = w_head;
        end else begin : g_next
            assign w_cell_in = w_tok[g-1];
        end

        lcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_active     (w_active[g]),
            .i_load       (w_load_en[g]),
            .i_load_sym   (i_in_data.symbol),
            .i_load_score (i_in_data.border_value),
            .i_tok        (w_cell_in),
            .o_tok        (w_tok[g]),
            .o_score      (w_score[g])
        );
    end

    // Pick the wavefront leaving the bottom row, and the addressed border entry.
    always_comb begin
        w_tap      = '0;
        w_rd_score = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (w_bottom[i]) begin
                w_tap = w_tok[i];
            end
            if (32'(i_in_data.row_index) == 32'(i)) begin
                w_rd_score = w_score[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= HEIGHT_W'(64);
            r_cols <= WIDTH_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS: r_rows <= i_cfg_data[HEIGHT_W-1:0];
                REG_COLS: r_cols <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_top  <= '0;
            r_col_count <= '0;
        end else if (w_in_acc) begin
            case (i_in_data.cmd)
                CMD_LOAD: begin
                    r_col_count <= '0;
                end
                CMD_CORNER: begin
                    r_prev_top  <= i_in_data.border_value;
                    r_col_count <= '0;
                end
                CMD_COLUMN: begin
                    r_prev_top  <= i_in_data.border_value;
                    r_col_count <= n_col_count;
                end
                CMD_READ: ;
                default: ;
            endcase
        end
    end

    // Output register: a column leaving the chain, or a border read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_tap.valid || w_rd_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_tap.valid) begin
                r_out <= '{score: w_tap.up, kind: KIND_BOTTOM, last: w_tap.last};
            end else if (w_rd_acc) begin
                r_out <= '{score: (32'(i_in_data.row_index) < 32'(MAX_ROWS)) ? w_rd_score
                                                                           : '0,
                           kind: KIND_BORDER, last: 1'b0};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The clamped height selects exactly one bottom row.
    a_one_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_bottom))
        else $error("bottom row select is not one-hot");

    // A border read never competes with a column leaving the chain.
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_acc |-> !w_tap.valid)
        else $error("border read accepted with a column at the chain bottom");

    // A column at the bottom is not lost while the output stalls.
    a_tap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tap.valid && !w_adv) |=> w_tap.valid)
        else $error("column result dropped under output stall");

    // Border reads never carry the last-column mark.
    a_border_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_BORDER)) |-> !o_out_data.last)
        else $error("border read marked as last column");

endmodule
